### rtl/ierb_pkg.sv
// Package: shared types and constants of the ICMPv6 echo request builder.
`timescale 1ns / 1ps
`default_nettype none
package ierb_pkg;

	// Packet layout
	localparam int unsigned WORDS_PER_PKT = 24;
	localparam int unsigned IDX_W         = 5;
	localparam int unsigned CFG_DATA_W    = 64;
	localparam int unsigned CFG_IDX_W     = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS_PER_PKT - 1);

	// Fixed header fields
	localparam logic [3:0]  IP_VERSION     = 4'h6;
	localparam logic [15:0] PAYLOAD_LEN    = 16'd8;
	localparam logic [7:0]  NEXT_HDR_ICMP6 = 8'h3A;
	localparam logic [15:0] ECHO_TYPE_CODE = 16'h8000;

	// Checksum seed: payload length + next header + type/code
	localparam logic [15:0] CSUM_SEED = 16'h8042;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HI = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_LO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HI = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_LO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDENT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOP    = 3'd6;

	// Reset values of the registers
	localparam logic [15:0] IDENT_RST = 16'd48879;
	localparam logic [19:0] FLOW_RST  = 20'd782068;
	localparam logic [7:0]  HOP_RST   = 8'd255;

	typedef struct packed {
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [15:0] ident;
		logic [19:0] flow;
		logic [7:0]  hop;
	} cfg_t;

	typedef struct packed {
		logic [15:0]      word;
		logic [IDX_W-1:0] index;
		logic             last;
	} word_t;

endpackage
`default_nettype wire

### rtl/ierb_req_if.sv
// Interface: send request channel (valid/ready).
`timescale 1ns / 1ps
`default_nettype none
interface ierb_req_if;
	logic valid;
	logic ready;
	logic send_request;

	modport source (output valid, output send_request, input ready);
	modport sink (input valid, input send_request, output ready);
endinterface
`default_nettype wire

### rtl/ierb_word_if.sv
// Interface: packet word channel (valid/ready).
`timescale 1ns / 1ps
`default_nettype none
interface ierb_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] packet_word;
	logic [4:0]  word_index;
	logic        last_word;

	modport source (output valid, output packet_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input packet_word, input word_index, input last_word,
		output ready);
endinterface
`default_nettype wire

### rtl/ierb_cfg_regs.sv
// Configuration register file: addresses, identifier, flow label, hop limit.
`timescale 1ns / 1ps
`default_nettype none
module ierb_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ierb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ierb_pkg::CFG_DATA_W-1:0]   cfg_data,
	output ierb_pkg::cfg_t                         cfg
);
	import ierb_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_hi <= '0;
			cfg_q.src_lo <= '0;
			cfg_q.dst_hi <= '0;
			cfg_q.dst_lo <= '0;
			cfg_q.ident  <= IDENT_RST;
			cfg_q.flow   <= FLOW_RST;
			cfg_q.hop    <= HOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_HI: cfg_q.src_hi <= cfg_data;
				REG_SRC_LO: cfg_q.src_lo <= cfg_data;
				REG_DST_HI: cfg_q.dst_hi <= cfg_data;
				REG_DST_LO: cfg_q.dst_lo <= cfg_data;
				REG_IDENT:  cfg_q.ident  <= cfg_data[15:0];
				REG_FLOW:   cfg_q.flow   <= cfg_data[19:0];
				REG_HOP:    cfg_q.hop    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/ierb_word_gen.sv
// Word generator: request slot, word counter, sequence number and running checksum.
`timescale 1ns / 1ps
`default_nettype none
module ierb_word_gen (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ierb_pkg::cfg_t cfg,
	ierb_req_if.sink           req,
	input  wire logic          take,
	output logic               gen_valid,
	output ierb_pkg::word_t    gen_word
);
	import ierb_pkg::*;

	logic             pend_q;
	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      seq_q;
	logic [15:0]      acc_q;

	logic        advance;
	logic        finishing;
	logic        start;
	logic        req_xfer;
	logic [15:0] word;
	logic [15:0] term;
	logic [15:0] acc_base;
	logic [16:0] acc_sum;
	logic [15:0] acc_next;

	// One request may wait while a packet is going out
	assign req.ready = !pend_q;
	assign req_xfer  = req.valid && req.ready && req.send_request;

	assign advance   = active_q && take;
	assign finishing = advance && (idx_q == LAST_IDX);
	assign start     = pend_q && (!active_q || finishing);

	// Word select for the current position
	always_comb begin
		word = '0;
		unique case (idx_q)
			5'd0:  word = {IP_VERSION, 8'h00, cfg.flow[19:16]};
			5'd1:  word = cfg.flow[15:0];
			5'd2:  word = PAYLOAD_LEN;
			5'd3:  word = {NEXT_HDR_ICMP6, cfg.hop};
			5'd4:  word = cfg.src_hi[63:48];
			5'd5:  word = cfg.src_hi[47:32];
			5'd6:  word = cfg.src_hi[31:16];
			5'd7:  word = cfg.src_hi[15:0];
			5'd8:  word = cfg.src_lo[63:48];
			5'd9:  word = cfg.src_lo[47:32];
			5'd10: word = cfg.src_lo[31:16];
			5'd11: word = cfg.src_lo[15:0];
			5'd12: word = cfg.dst_hi[63:48];
			5'd13: word = cfg.dst_hi[47:32];
			5'd14: word = cfg.dst_hi[31:16];
			5'd15: word = cfg.dst_hi[15:0];
			5'd16: word = cfg.dst_lo[63:48];
			5'd17: word = cfg.dst_lo[47:32];
			5'd18: word = cfg.dst_lo[31:16];
			5'd19: word = cfg.dst_lo[15:0];
			5'd20: word = ECHO_TYPE_CODE;
			5'd21: word = ~acc_q;
			5'd22: word = cfg.ident;
			5'd23: word = seq_q;
			default: word = '0;
		endcase
	end

	// Checksum term folded in as each word leaves; the fixed fields go in as a seed
	always_comb begin
		term     = '0;
		acc_base = acc_q;
		if (idx_q == '0) begin
			acc_base = CSUM_SEED;
		end else if (idx_q == 5'd1) begin
			term = cfg.ident;
		end else if (idx_q == 5'd2) begin
			term = seq_q;
		end else if (idx_q >= 5'd4 && idx_q <= 5'd19) begin
			term = word;
		end
	end

	// Ones' complement add with end-around carry
	assign acc_sum  = {1'b0, acc_base} + {1'b0, term};
	assign acc_next = acc_sum[15:0] + {15'd0, acc_sum[16]};

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			active_q <= 1'b0;
			idx_q    <= '0;
			seq_q    <= '0;
			acc_q    <= '0;
		end else begin
			pend_q <= (pend_q && !start) || req_xfer;
			if (start) begin
				active_q <= 1'b1;
			end else if (finishing) begin
				active_q <= 1'b0;
			end
			if (start) begin
				idx_q <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 5'd1;
			end
			if (finishing) begin
				seq_q <= seq_q + 16'd1;
			end
			if (advance) begin
				acc_q <= acc_next;
			end
		end
	end

	assign gen_valid      = active_q;
	assign gen_word.word  = word;
	assign gen_word.index = idx_q;
	assign gen_word.last  = (idx_q == LAST_IDX);

endmodule
`default_nettype wire

### rtl/ierb_out_reg.sv
// Output register: holds one packet word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module ierb_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            gen_valid,
	input  wire ierb_pkg::word_t gen_word,
	output logic                 take,
	ierb_word_if.source          pkt
);
	import ierb_pkg::*;

	logic  valid_q;
	word_t data_q;

	// Load whenever the register is empty or being drained
	assign take = !valid_q || pkt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= gen_valid;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (take && gen_valid) begin
			data_q <= gen_word;
		end
	end

	assign pkt.valid       = valid_q;
	assign pkt.packet_word = data_q.word;
	assign pkt.word_index  = data_q.index;
	assign pkt.last_word   = data_q.last;

endmodule
`default_nettype wire

### rtl/icmpv6_echo_request_builder_top.sv
// Top level: ICMPv6 echo request builder.
//
// Channels: req (sink) carries send_request; a transfer with send_request = 1
// asks for one 48-byte IPv6 packet holding an ICMPv6 echo request, a transfer
// with send_request = 0 is dropped. pkt (source) delivers the packet as 24
// big-endian 16-bit words with word_index 0..23 and last_word on word 23.
// The configuration port (cfg_we, cfg_index, cfg_data) writes addresses,
// identifier, flow label and hop limit; write it only while no packet is out.
// A request waits in the request slot; its words pass the output register.
// Throughput: one word per cycle while pkt does not stall, set by the word
// counter that walks the packet one word at a time. One further request
// is held while a packet is being sent, so packets follow back to back.
// Reset clears the sequence number to 0, loads register defaults and empties
// the request slot and output register. When pkt stalls, the output register
// holds its word and the word counter, checksum and sequence number wait.
`timescale 1ns / 1ps
`default_nettype none
module icmpv6_echo_request_builder_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ierb_req_if.sink                               req,
	ierb_word_if.source                            pkt,
	input  wire logic                              cfg_we,
	input  wire logic [ierb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ierb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ierb_pkg::*;

	cfg_t  cfg;
	word_t gen_word;
	logic  gen_valid;
	logic  take;

	ierb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ierb_word_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.take      (take),
		.gen_valid (gen_valid),
		.gen_word  (gen_word)
	);

	ierb_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.gen_valid (gen_valid),
		.gen_word  (gen_word),
		.take      (take),
		.pkt       (pkt)
	);

endmodule
`default_nettype wire
